// ===== hw/rtl/qmr_pkg.sv =====
// ----------------------------------------------------------------------------
// qmr_pkg
// Types, constants and the fixed-point product helper shared by the
// quaternion product and rotation pipeline.
// ----------------------------------------------------------------------------
package qmr_pkg;

  localparam int unsigned QW = 32;           // Q16.16 component width
  localparam int unsigned CW = QW + 1;       // conjugated component width
  localparam int unsigned FRAC = 16;         // fraction bits
  localparam int unsigned PW = 48;           // truncated product width
  localparam int unsigned SW = PW + 2;       // four-term sum width
  localparam int unsigned NPROD = 16;        // products per Hamilton product

  localparam logic signed [SW-1:0] SUM_MAX = SW'(64'sd2147483647);
  localparam logic signed [SW-1:0] SUM_MIN = -SW'(64'sd2147483648);

  localparam logic FUNC_PRODUCT = 1'b0;
  localparam logic FUNC_ROTATE  = 1'b1;

  typedef logic signed [QW-1:0] comp_t;
  typedef logic signed [CW-1:0] ccomp_t;
  typedef logic signed [PW-1:0] prod_w_t;

  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
    comp_t w;
  } quat_t;

  typedef struct packed {
    ccomp_t x;
    ccomp_t y;
    ccomp_t z;
    ccomp_t w;
  } cquat_t;

  typedef struct packed {
    logic  func;
    comp_t a_x;
    comp_t a_y;
    comp_t a_z;
    comp_t a_w;
    comp_t b_x;
    comp_t b_y;
    comp_t b_z;
    comp_t b_w;
  } in_t;

  typedef struct packed {
    comp_t r_x;
    comp_t r_y;
    comp_t r_z;
    comp_t r_w;
    logic  overflow;
  } out_t;

  // Q16.16 product rounded toward minus infinity. The exact product always
  // fits in 64 signed bits, so bit 63 carries the sign.
  function automatic prod_w_t qmul(input comp_t p, input ccomp_t q);
    logic signed [CW+QW-1:0] m;
    m = (CW+QW)'(p) * (CW+QW)'(q);
    return m[63:FRAC];
  endfunction

endpackage

// ===== hw/rtl/qmr_mul_array.sv =====
// ----------------------------------------------------------------------------
// qmr_mul_array
// The sixteen truncated Q16.16 products of one Hamilton product p*q,
// grouped by result component (x, y, z, w), four terms each.
// ----------------------------------------------------------------------------
module qmr_mul_array (
  input  qmr_pkg::quat_t   p_i,
  input  qmr_pkg::cquat_t  q_i,
  output qmr_pkg::prod_w_t prod_o [qmr_pkg::NPROD]
);

  // x terms: pw*qx, px*qw, py*qz, pz*qy (last one subtracted)
  assign prod_o[0]  = qmr_pkg::qmul(p_i.w, q_i.x);
  assign prod_o[1]  = qmr_pkg::qmul(p_i.x, q_i.w);
  assign prod_o[2]  = qmr_pkg::qmul(p_i.y, q_i.z);
  assign prod_o[3]  = qmr_pkg::qmul(p_i.z, q_i.y);
  // y terms: pw*qy, py*qw, pz*qx, px*qz (last one subtracted)
  assign prod_o[4]  = qmr_pkg::qmul(p_i.w, q_i.y);
  assign prod_o[5]  = qmr_pkg::qmul(p_i.y, q_i.w);
  assign prod_o[6]  = qmr_pkg::qmul(p_i.z, q_i.x);
  assign prod_o[7]  = qmr_pkg::qmul(p_i.x, q_i.z);
  // z terms: pw*qz, pz*qw, px*qy, py*qx (last one subtracted)
  assign prod_o[8]  = qmr_pkg::qmul(p_i.w, q_i.z);
  assign prod_o[9]  = qmr_pkg::qmul(p_i.z, q_i.w);
  assign prod_o[10] = qmr_pkg::qmul(p_i.x, q_i.y);
  assign prod_o[11] = qmr_pkg::qmul(p_i.y, q_i.x);
  // w terms: pw*qw minus the three vector products
  assign prod_o[12] = qmr_pkg::qmul(p_i.w, q_i.w);
  assign prod_o[13] = qmr_pkg::qmul(p_i.x, q_i.x);
  assign prod_o[14] = qmr_pkg::qmul(p_i.y, q_i.y);
  assign prod_o[15] = qmr_pkg::qmul(p_i.z, q_i.z);

endmodule

// ===== hw/rtl/qmr_sum_sat.sv =====
// ----------------------------------------------------------------------------
// qmr_sum_sat
// Adds the four signed terms of each Hamilton component and saturates the
// sums to the signed 32-bit range, flagging any clamp.
// ----------------------------------------------------------------------------
module qmr_sum_sat (
  input  qmr_pkg::prod_w_t prod_i [qmr_pkg::NPROD],
  output qmr_pkg::quat_t   r_o,
  output logic             ovf_o
);

  logic signed [qmr_pkg::SW-1:0] sum_x, sum_y, sum_z, sum_w;
  logic [3:0] clamp;

  function automatic qmr_pkg::comp_t sat(input logic signed [qmr_pkg::SW-1:0] s);
    if (s > qmr_pkg::SUM_MAX) begin
      return qmr_pkg::QW'(qmr_pkg::SUM_MAX);
    end else if (s < qmr_pkg::SUM_MIN) begin
      return qmr_pkg::QW'(qmr_pkg::SUM_MIN);
    end
    return qmr_pkg::QW'(s);
  endfunction

  function automatic logic out_of_range(input logic signed [qmr_pkg::SW-1:0] s);
    return (s > qmr_pkg::SUM_MAX) || (s < qmr_pkg::SUM_MIN);
  endfunction

  assign sum_x = qmr_pkg::SW'(prod_i[0]) + qmr_pkg::SW'(prod_i[1])
               + qmr_pkg::SW'(prod_i[2]) - qmr_pkg::SW'(prod_i[3]);
  assign sum_y = qmr_pkg::SW'(prod_i[4]) + qmr_pkg::SW'(prod_i[5])
               + qmr_pkg::SW'(prod_i[6]) - qmr_pkg::SW'(prod_i[7]);
  assign sum_z = qmr_pkg::SW'(prod_i[8]) + qmr_pkg::SW'(prod_i[9])
               + qmr_pkg::SW'(prod_i[10]) - qmr_pkg::SW'(prod_i[11]);
  assign sum_w = qmr_pkg::SW'(prod_i[12]) - qmr_pkg::SW'(prod_i[13])
               - qmr_pkg::SW'(prod_i[14]) - qmr_pkg::SW'(prod_i[15]);

  assign r_o.x = sat(sum_x);
  assign r_o.y = sat(sum_y);
  assign r_o.z = sat(sum_z);
  assign r_o.w = sat(sum_w);

  assign clamp = {out_of_range(sum_x), out_of_range(sum_y),
                  out_of_range(sum_z), out_of_range(sum_w)};
  assign ovf_o = |clamp;

endmodule

// ===== hw/rtl/quaternion_multiply_rotate_core.sv =====
// An accepted item passes through the registers of stages A, B, C and D in turn.
// One item per cycle while the output is not stalled; the multiplier banks and
// adder trees of both Hamilton passes each have their own register stage.
// A stage holds its item only while the stage after it is full and stalled.
// Reset clears the stage valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
// quaternion_multiply_rotate_core
// Pipelined Q16.16 Hamilton product a*b and rotation a*(v,0)*conj(a).
// ----------------------------------------------------------------------------
module quaternion_multiply_rotate_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  qmr_pkg::in_t    in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output qmr_pkg::out_t   out_data_o
);

  // Stage A: first product bank.
  logic              valid_a_q;
  logic              func_a_q;
  qmr_pkg::quat_t    a_a_q;
  qmr_pkg::prod_w_t  prod_a_q [qmr_pkg::NPROD];
  // Stage B: first sums, t = a*b or a*(v,0).
  logic              valid_b_q;
  logic              func_b_q;
  qmr_pkg::quat_t    a_b_q;
  qmr_pkg::quat_t    t_b_q;
  logic              ovf_b_q;
  // Stage C: second product bank t*conj(a).
  logic              valid_c_q;
  logic              func_c_q;
  qmr_pkg::quat_t    t_c_q;
  logic              ovf_c_q;
  qmr_pkg::prod_w_t  prod_c_q [qmr_pkg::NPROD];
  // Stage D: output register.
  logic              valid_d_q;
  qmr_pkg::out_t     out_q;

  logic rdy_a, rdy_b, rdy_c, rdy_d;

  qmr_pkg::quat_t    a_in;
  qmr_pkg::cquat_t   q_in;
  qmr_pkg::prod_w_t  prod_a_d [qmr_pkg::NPROD];
  qmr_pkg::quat_t    t_d;
  logic              ovf_t_d;
  qmr_pkg::cquat_t   conj_a;
  qmr_pkg::prod_w_t  prod_c_d [qmr_pkg::NPROD];
  qmr_pkg::quat_t    r_d;
  logic              ovf_r_d;
  qmr_pkg::out_t     out_d;

  // A stage may take a new item when it is empty or its item moves on.
  assign rdy_d = !valid_d_q || !out_stall_i;
  assign rdy_c = !valid_c_q || rdy_d;
  assign rdy_b = !valid_b_q || rdy_c;
  assign rdy_a = !valid_a_q || rdy_b;
  assign in_stall_o = !rdy_a;

  assign a_in.x = in_data_i.a_x;
  assign a_in.y = in_data_i.a_y;
  assign a_in.z = in_data_i.a_z;
  assign a_in.w = in_data_i.a_w;

  // For a rotation the second operand is the pure vector (v, 0).
  assign q_in.x = qmr_pkg::CW'(in_data_i.b_x);
  assign q_in.y = qmr_pkg::CW'(in_data_i.b_y);
  assign q_in.z = qmr_pkg::CW'(in_data_i.b_z);
  assign q_in.w = (in_data_i.func == qmr_pkg::FUNC_ROTATE) ? '0
                                                           : qmr_pkg::CW'(in_data_i.b_w);

  qmr_mul_array u_mul_a (
    .p_i    (a_in),
    .q_i    (q_in),
    .prod_o (prod_a_d)
  );

  qmr_sum_sat u_sum_b (
    .prod_i (prod_a_q),
    .r_o    (t_d),
    .ovf_o  (ovf_t_d)
  );

  // The conjugate is negated one bit wider, so the most negative value is exact.
  assign conj_a.x = -qmr_pkg::CW'(a_b_q.x);
  assign conj_a.y = -qmr_pkg::CW'(a_b_q.y);
  assign conj_a.z = -qmr_pkg::CW'(a_b_q.z);
  assign conj_a.w = qmr_pkg::CW'(a_b_q.w);

  qmr_mul_array u_mul_c (
    .p_i    (t_b_q),
    .q_i    (conj_a),
    .prod_o (prod_c_d)
  );

  qmr_sum_sat u_sum_d (
    .prod_i (prod_c_q),
    .r_o    (r_d),
    .ovf_o  (ovf_r_d)
  );

  always_comb begin
    if (func_c_q == qmr_pkg::FUNC_ROTATE) begin
      out_d.r_x      = r_d.x;
      out_d.r_y      = r_d.y;
      out_d.r_z      = r_d.z;
      out_d.r_w      = '0;
      out_d.overflow = ovf_c_q | ovf_r_d;
    end else begin
      out_d.r_x      = t_c_q.x;
      out_d.r_y      = t_c_q.y;
      out_d.r_z      = t_c_q.z;
      out_d.r_w      = t_c_q.w;
      out_d.overflow = ovf_c_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
      valid_d_q <= 1'b0;
    end else begin
      if (rdy_a) begin
        valid_a_q <= in_valid_i;
      end
      if (rdy_b) begin
        valid_b_q <= valid_a_q;
      end
      if (rdy_c) begin
        valid_c_q <= valid_b_q;
      end
      if (rdy_d) begin
        valid_d_q <= valid_c_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && in_valid_i) begin
      func_a_q <= in_data_i.func;
      a_a_q    <= a_in;
      prod_a_q <= prod_a_d;
    end
    if (rdy_b && valid_a_q) begin
      func_b_q <= func_a_q;
      a_b_q    <= a_a_q;
      t_b_q    <= t_d;
      ovf_b_q  <= ovf_t_d;
    end
    if (rdy_c && valid_b_q) begin
      func_c_q <= func_b_q;
      t_c_q    <= t_b_q;
      ovf_c_q  <= ovf_b_q;
      prod_c_q <= prod_c_d;
    end
    if (rdy_d && valid_c_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = valid_d_q;
  assign out_data_o  = out_q;

endmodule
